[rtl/swtq_pkg.sv]
// Shared types and constants for the sleep/wakeup timer queue.
// No dependencies; imported by swtq_cell and sleep_wakeup_timer_queue_unit.
package swtq_pkg;

    localparam int          ID_W      = 16;
    localparam int          TIME_W    = 32;
    localparam int          TPS_W     = 10;
    localparam int          SECS_W    = 16;
    localparam int          PROD_W    = (SECS_W - 1) + TPS_W;
    localparam logic [TPS_W-1:0] TPS_RESET = 10'd10;

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [2:0] {
        K_QUEUED = 3'd0,
        K_REJECT = 3'd1,
        K_BUSY   = 3'd2,
        K_WOKEN  = 3'd3,
        K_NONE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_INS,
        S_WAKE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] wake;
    } t_entry;

    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] wake;
    } t_cell_ctrl;

endpackage

[rtl/sleep_wakeup_timer_queue_unit.sv]
// Top level of the sleep/wakeup timer queue: control, tick counter, slot map
// and the row of swtq_cell instances. Depends on swtq_pkg and swtq_cell.

// Sleeping processes sit in a row of cells kept sorted by wake time, earliest
// in the first cell. A sleep request is captured with the seconds-by-rate
// multiply and the slot quotient, then slot and saturated wake time are
// registered, then every cell compares and shifts in parallel; rejected and
// busy requests finish at the slot step. A tick bumps the counter on capture,
// then one woken process per cycle is given as the head of the row is popped,
// while the output is not stalled, or a single none result when none is due.
// Results leave through a one-deep output register; a stalled result holds the
// block only when the next result is ready. No clearing pass is needed after reset.
module sleep_wakeup_timer_queue_unit
    import swtq_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TPS_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_command,
    input  logic [ID_W-1:0]   i_process_id,
    input  logic [SECS_W-1:0] i_sleep_seconds,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [2:0]        o_kind,
    output logic [ID_W-1:0]   o_woken_id,
    output logic              o_last
);

    localparam int          SW    = $clog2(SLOTS);
    localparam logic [31:0] RECIP = 32'((64'h1_0000_0000 / SLOTS) + 1);

    t_state              r_state, n_state;
    logic [TPS_W-1:0]    r_tps;
    logic [TIME_W-1:0]   r_tick_count;
    logic [SLOTS-1:0]    r_busy;
    logic [ID_W-1:0]     r_pid;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [ID_W-1:0]     r_quot;
    logic [TIME_W-1:0]   r_wake;
    logic [SW-1:0]       r_slot;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [ID_W-1:0]     r_id;
    logic                r_last;

    logic                accept;
    logic                out_free;
    logic [47:0]         pid_x_recip;
    logic [ID_W-1:0]     slot_full;
    logic [SW-1:0]       calc_slot;
    logic [TIME_W:0]     wake_sum;
    logic [TIME_W-1:0]   calc_wake;
    logic                head_due;
    logic                next_due;

    logic                emit;
    t_kind               emit_kind;
    logic [ID_W-1:0]     emit_id;
    logic                emit_last;
    logic                do_ins;
    logic                do_pop;
    logic                cap_wake;

    t_cell_ctrl          cell_ctrl;
    t_entry              cell_q    [SLOTS];
    logic [SW-1:0]       cell_slot [SLOTS];
    logic                cell_keep [SLOTS];
    logic [SLOTS-1:0]    cell_valid;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign pid_x_recip = 48'(i_process_id) * 48'(RECIP);
    assign slot_full   = r_pid - 16'(r_quot * 16'(SLOTS));
    assign calc_slot   = slot_full[SW-1:0];
    assign wake_sum    = {1'b0, r_tick_count} + 33'(r_prod);
    assign calc_wake   = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];

    assign head_due = cell_q[0].valid && (cell_q[0].wake <= r_tick_count);
    assign next_due = cell_q[1].valid && (cell_q[1].wake <= r_tick_count);

    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        emit_kind = K_NONE;
        emit_id   = '0;
        emit_last = 1'b1;
        do_ins    = 1'b0;
        do_pop    = 1'b0;
        cap_wake  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_command == CMD_TICK) ? S_WAKE : S_CALC;
                end
            end
            S_CALC: begin
                if (r_neg) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_kind = K_REJECT;
                        emit_id   = r_pid;
                        n_state   = S_IDLE;
                    end
                end else if (r_busy[calc_slot]) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_kind = K_BUSY;
                        emit_id   = r_pid;
                        n_state   = S_IDLE;
                    end
                end else begin
                    cap_wake = 1'b1;
                    n_state  = S_INS;
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = K_QUEUED;
                    emit_id   = r_pid;
                    do_ins    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_WAKE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (head_due) begin
                        emit_kind = K_WOKEN;
                        emit_id   = cell_q[0].owner;
                        emit_last = !next_due;
                        do_pop    = 1'b1;
                        if (!next_due) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tps        <= TPS_RESET;
            r_tick_count <= '0;
            r_busy       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (accept && (i_command == CMD_TICK)) begin
                r_tick_count <= 32'(r_tick_count + 32'd1);
            end
            if (do_ins) begin
                r_busy[r_slot] <= 1'b1;
            end
            if (do_pop) begin
                r_busy[cell_slot[0]] <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pid  <= i_process_id;
            r_neg  <= i_sleep_seconds[SECS_W-1];
            r_prod <= PROD_W'(i_sleep_seconds[SECS_W-2:0]) * PROD_W'(r_tps);
            r_quot <= pid_x_recip[47:32];
        end
        if (cap_wake) begin
            r_wake <= calc_wake;
            r_slot <= calc_slot;
        end
        if (emit) begin
            r_kind <= emit_kind;
            r_id   <= emit_id;
            r_last <= emit_last;
        end
    end

    assign cell_ctrl = '{ins: do_ins, pop: do_pop, owner: r_pid, wake: r_wake};

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        t_entry        left, right;
        logic [SW-1:0] left_slot, right_slot;
        logic          left_keep;

        if (i == 0) begin : g_first
            assign left      = '0;
            assign left_slot = '0;
            assign left_keep = 1'b1;
        end else begin : g_inner
            assign left      = cell_q[i-1];
            assign left_slot = cell_slot[i-1];
            assign left_keep = cell_keep[i-1];
        end

        if (i == SLOTS - 1) begin : g_last
            assign right      = '0;
            assign right_slot = '0;
        end else begin : g_body
            assign right      = cell_q[i+1];
            assign right_slot = cell_slot[i+1];
        end

        swtq_cell #(
            .SW (SW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_new_slot   (r_slot),
            .i_left       (left),
            .i_left_slot  (left_slot),
            .i_left_keep  (left_keep),
            .i_right      (right),
            .i_right_slot (right_slot),
            .o_entry      (cell_q[i]),
            .o_slot       (cell_slot[i]),
            .o_keep       (cell_keep[i])
        );

        assign cell_valid[i] = cell_q[i].valid;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_woken_id  = r_id;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_q[0].valid && cell_q[1].valid) |-> (cell_q[0].wake <= cell_q[1].wake))
        else $error("head entries out of wake order");

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_q[1].valid |-> cell_q[0].valid)
        else $error("gap at head of cell chain");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == $countones(cell_valid))
        else $error("slot map and cell chain disagree");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind != K_WOKEN)) |-> o_last)
        else $error("single-result request not marked last");
`endif

endmodule

[rtl/swtq_cell.sv]
// One cell of the sorted wake-time chain: holds one entry and its slot.
// Depends on swtq_pkg; instantiated in a row by sleep_wakeup_timer_queue_unit.
module swtq_cell
    import swtq_pkg::*;
#(
    parameter int SW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctrl    i_ctrl,
    input  logic [SW-1:0] i_new_slot,
    input  t_entry        i_left,
    input  logic [SW-1:0] i_left_slot,
    input  logic          i_left_keep,
    input  t_entry        i_right,
    input  logic [SW-1:0] i_right_slot,
    output t_entry        o_entry,
    output logic [SW-1:0] o_slot,
    output logic          o_keep
);

    logic              r_valid, n_valid;
    logic [ID_W-1:0]   r_owner, n_owner;
    logic [TIME_W-1:0] r_wake,  n_wake;
    logic [SW-1:0]     r_slot,  n_slot;
    logic              keep;

    // strictly earlier entries stay put; equal wake times go behind the new one
    assign keep = r_valid && (r_wake < i_ctrl.wake);

    always_comb begin
        n_valid = r_valid;
        n_owner = r_owner;
        n_wake  = r_wake;
        n_slot  = r_slot;
        if (i_ctrl.ins) begin
            if (!keep) begin
                if (i_left_keep) begin
                    n_valid = 1'b1;
                    n_owner = i_ctrl.owner;
                    n_wake  = i_ctrl.wake;
                    n_slot  = i_new_slot;
                end else begin
                    n_valid = i_left.valid;
                    n_owner = i_left.owner;
                    n_wake  = i_left.wake;
                    n_slot  = i_left_slot;
                end
            end
        end else if (i_ctrl.pop) begin
            n_valid = i_right.valid;
            n_owner = i_right.owner;
            n_wake  = i_right.wake;
            n_slot  = i_right_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_owner <= n_owner;
        r_wake  <= n_wake;
        r_slot  <= n_slot;
    end

    assign o_entry = '{valid: r_valid, owner: r_owner, wake: r_wake};
    assign o_slot  = r_slot;
    assign o_keep  = keep;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for sleep_wakeup_timer_queue_unit: directed and random
// sleep requests and ticks, checked against an in-bench timer-queue predictor.
// Depends on swtq_pkg and the unit RTL.
module tb;
    import swtq_pkg::*;

    localparam int SLOT_COUNT = 64;

    typedef struct {
        t_kind           kind;
        logic [ID_W-1:0] id;
        logic            last;
    } t_wake_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [TPS_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_command;
    logic [ID_W-1:0]   i_process_id;
    logic [SECS_W-1:0] i_sleep_seconds;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_kind;
    logic [ID_W-1:0]   o_woken_id;
    logic              o_last;

    // timer queue state as predicted
    logic [TIME_W-1:0] tick_total;
    logic [TPS_W-1:0]  rate;
    bit                occupied [SLOT_COUNT];
    logic [ID_W-1:0]   owner_of [SLOT_COUNT];
    logic [TIME_W-1:0] wake_at  [SLOT_COUNT];
    int                wake_order [$];

    t_wake_result      due_results [$];
    int                fail_count = 0;
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;

    sleep_wakeup_timer_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_process_id    (i_process_id),
        .i_sleep_seconds (i_sleep_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_woken_id      (o_woken_id),
        .o_last          (o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic void push_result(input t_kind kind, input logic [ID_W-1:0] id,
                                        input logic last);
        t_wake_result r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        due_results.push_back(r);
    endfunction

    function automatic void apply_timer_request(input logic cmd, input logic [ID_W-1:0] pid,
                                                input logic [SECS_W-1:0] secs);
        logic [63:0] wake;
        int          slot;
        int          pos;
        int          head;
        bit          woke;
        if (cmd == CMD_SLEEP) begin
            slot = int'(pid) % SLOT_COUNT;
            if (secs[SECS_W-1]) begin
                push_result(K_REJECT, pid, 1'b1);
            end else if (occupied[slot]) begin
                push_result(K_BUSY, pid, 1'b1);
            end else begin
                wake = {32'd0, tick_total} + {48'd0, secs} * {54'd0, rate};
                if (wake > 64'h0000_0000_FFFF_FFFF) begin
                    wake = 64'h0000_0000_FFFF_FFFF;
                end
                occupied[slot] = 1'b1;
                owner_of[slot] = pid;
                wake_at[slot]  = wake[TIME_W-1:0];
                // new request goes ahead of equal wake times
                pos = 0;
                while (pos < wake_order.size() && wake_at[wake_order[pos]] < wake[TIME_W-1:0])
                    pos++;
                wake_order.insert(pos, slot);
                push_result(K_QUEUED, pid, 1'b1);
            end
        end else begin
            tick_total = tick_total + 1'b1;
            woke = 1'b0;
            while (wake_order.size() != 0 && wake_at[wake_order[0]] <= tick_total) begin
                head = wake_order.pop_front();
                occupied[head] = 1'b0;
                push_result(K_WOKEN, owner_of[head], 1'b0);
                woke = 1'b1;
            end
            if (woke) begin
                due_results[$].last = 1'b1;
            end else begin
                push_result(K_NONE, '0, 1'b1);
            end
        end
    endfunction

    task automatic send_req(input logic cmd, input logic [ID_W-1:0] pid,
                            input logic [SECS_W-1:0] secs);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_process_id    <= pid;
        i_sleep_seconds <= secs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_timer_request(cmd, pid, secs);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rate(input logic [TPS_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rate = value;
    endtask

    // reset rate: empty tick, negative seconds, busy slot, longest sleep
    task automatic test_reset_defaults();
        send_req(CMD_TICK, 16'h0000, 16'h0000);
        send_req(CMD_SLEEP, 16'h0000, 16'h0000);
        send_req(CMD_SLEEP, 16'hFFFF, 16'h7FFF);
        send_req(CMD_SLEEP, 16'h1234, 16'h8000);
        send_req(CMD_SLEEP, 16'hFFFF, 16'hFFFF);
        send_req(CMD_SLEEP, 16'h0040, 16'h0001);
        send_req(CMD_TICK, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_equal_wake_order();
        write_rate(10'd1);
        send_req(CMD_SLEEP, 16'h0001, 16'h0001);
        send_req(CMD_SLEEP, 16'h0002, 16'h0001);
        send_req(CMD_SLEEP, 16'h0003, 16'h0001);
        send_req(CMD_SLEEP, 16'h0004, 16'h0000);
        send_req(CMD_TICK, 16'h0000, 16'h0000);
        send_req(CMD_TICK, 16'h0000, 16'h0000);
    endtask

    task automatic test_rate_extremes();
        write_rate(10'd1000);
        send_req(CMD_SLEEP, 16'h1005, 16'h7FFF);
        send_req(CMD_SLEEP, 16'h2045, 16'h0000);
        write_rate(10'd0);
        send_req(CMD_SLEEP, 16'h0006, 16'h7FFF);
        send_req(CMD_TICK, 16'h0000, 16'h0000);
    endtask

    // rate 0: every request wakes on the next tick, newest first
    task automatic test_mass_wakeup();
        for (int s = 8; s < 20; s++)
            send_req(CMD_SLEEP, {10'($urandom), 6'(s)}, 16'($urandom_range(0, 32767)));
        send_req(CMD_TICK, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count);
        logic [ID_W-1:0]   pid;
        logic [SECS_W-1:0] secs;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            pid  = 16'($urandom);
            secs = 16'($urandom_range(0, 4));
            if (pick < 40) begin
                send_req(CMD_TICK, pid, secs);
            end else begin
                if (pick >= 85 && pick < 90 && wake_order.size() != 0) begin
                    pid[5:0] = 6'(wake_order[$urandom_range(wake_order.size() - 1)]);
                end else if (pick >= 90 && pick < 95) begin
                    secs = {1'b1, 15'($urandom)};
                end else if (pick >= 95) begin
                    secs = {1'b0, 15'($urandom)};
                end
                send_req(CMD_SLEEP, pid, secs);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_wake_result want;
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                fail_count++;
                $display("%0t: no result due, got kind %0d id %h last %b",
                         $time, o_kind, o_woken_id, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind || o_woken_id !== want.id || o_last !== want.last) begin
                    fail_count++;
                    $display("%0t: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                             $time, want.kind, want.id, want.last, o_kind, o_woken_id, o_last);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("sleep_wakeup_timer_queue_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_SLEEP;
        i_process_id    <= '0;
        i_sleep_seconds <= '0;
        tick_total = '0;
        rate       = TPS_RESET;
        for (int s = 0; s < SLOT_COUNT; s++) occupied[s] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_equal_wake_order();
        test_rate_extremes();
        test_mass_wakeup();

        write_rate(10'd1);
        src_idle_pct   = 12;
        sink_stall_pct = 76;
        test_random_traffic(90);

        write_rate(10'd3);
        src_idle_pct   = 76;
        sink_stall_pct = 12;
        test_random_traffic(90);

        write_rate(10'd2);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(40);
        // hold off until every request has been answered
        drain_results();
        test_random_traffic(40);

        drain_results();
        if (fail_count == 0) begin
            $display("sleep_wakeup_timer_queue_unit: match");
        end else begin
            $display("sleep_wakeup_timer_queue_unit: mismatch");
        end
        $finish;
    end

endmodule
